// ===== design/msv_pkg.sv =====
// shared constants, types and constant tables for the sine voice
package msv_pkg;

  localparam int SAMPLE_RATE = 48000;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = 10;
  localparam int PHASE_W     = 32;
  localparam int GAIN_W      = 17;
  localparam int SMP_W       = 24;
  localparam int NOTE_CNT    = 128;
  localparam int CFG_AW      = 3;

  // milli-hertz per second of samples, divisor of the increment table
  localparam logic [63:0] RATE_MHZ = 64'(1000 * SAMPLE_RATE);

  localparam logic [3:0]  ST_NOTE_ON   = 4'h9;
  localparam logic [3:0]  ST_NOTE_OFF  = 4'h8;
  localparam logic [16:0] ATTACK_RST   = 17'd273;
  localparam logic [16:0] RELEASE_RST  = 17'd68;
  localparam logic [16:0] GAIN_UNITY   = 17'd65536;

  // register indexes on the configuration port
  localparam logic REG_ATTACK  = 1'b0;
  localparam logic REG_RELEASE = 1'b1;

  typedef logic signed [SMP_W-1:0] sine_rom_t [SINE_DEPTH];
  typedef logic [PHASE_W-1:0]      inc_rom_t  [NOTE_CNT];
  typedef logic [GAIN_W-1:0]       vel_rom_t  [NOTE_CNT];

  // controller to datapath commands
  typedef struct packed {
    logic tick_go;
    logic midi_go;
    logic ld_p1;
    logic ld_p2;
    logic ld_out;
  } msv_cmd_t;

  // one step of the taylor series, divisor per term
  function automatic logic [63:0] msv_term_div(input logic [63:0] p, input int i);
    logic [63:0] res;
    res = 64'd0;
    case (i)
      0: res = p / 64'd156;
      1: res = p / 64'd110;
      2: res = p / 64'd72;
      3: res = p / 64'd42;
      4: res = p / 64'd20;
      default: res = p / 64'd6;
    endcase
    return res;
  endfunction

  // full-wave sine table in q1.23 from the quarter-wave polynomial
  function automatic sine_rom_t msv_build_sine();
    sine_rom_t tab;
    logic [63:0] q, quad, r, m, x, x2, t, d, v;
    for (int n = 0; n < SINE_DEPTH; n++) begin
      q    = 64'(4 * n);
      quad = q / SINE_DEPTH;
      r    = q % SINE_DEPTH;
      m    = quad[0] ? (64'(SINE_DEPTH) - r) : r;
      x    = (64'd1686629713 * m + 64'(SINE_DEPTH / 2)) / SINE_DEPTH;
      x2   = (x * x) >> 30;
      t    = 64'd1073741824;
      for (int i = 0; i < 6; i++) begin
        d = msv_term_div((x2 * t) >> 30, i);
        t = (d >= 64'd1073741824) ? 64'd0 : 64'd1073741824 - d;
      end
      v = (((x * t) >> 30) + 64'd64) >> 7;
      if (v > 64'd8388607) v = 64'd8388607;
      tab[n] = (quad >= 64'd2) ? SMP_W'(-v) : SMP_W'(v);
    end
    return tab;
  endfunction

  function automatic logic [63:0] msv_top_mhz(input int k);
    logic [63:0] f;
    f = 64'd0;
    case (k)
      0: f = 64'd8372018;
      1: f = 64'd8869844;
      2: f = 64'd9397273;
      3: f = 64'd9956063;
      4: f = 64'd10548082;
      5: f = 64'd11175303;
      6: f = 64'd11839822;
      7: f = 64'd12543854;
      8: f = 64'd13289750;
      9: f = 64'd14080000;
      10: f = 64'd14917240;
      default: f = 64'd15804266;
    endcase
    return f;
  endfunction

  // phase increment per note, rounded; the octave shift is applied after
  // the division by the fixed rate
  function automatic inc_rom_t msv_build_inc();
    inc_rom_t tab;
    logic [63:0] num, den;
    int          sh;
    for (int n = 0; n < NOTE_CNT; n++) begin
      sh     = 10 - n / 12;
      den    = RATE_MHZ << sh;
      num    = (msv_top_mhz(n % 12) << PHASE_W) + (den >> 1);
      tab[n] = PHASE_W'((num / RATE_MHZ) >> sh);
    end
    return tab;
  endfunction

  // target gain per velocity, q1.16
  function automatic vel_rom_t msv_build_vel();
    vel_rom_t tab;
    for (int n = 0; n < NOTE_CNT; n++) begin
      tab[n] = GAIN_W'((n * 65536 + 63) / 127);
    end
    return tab;
  endfunction

endpackage

// ===== design/midi_sine_voice_ar_envelope.sv =====
// top level of the monophonic sine voice with linear attack and release
// a midi item (cmd 0) is taken and gives no result; a tick item
// (cmd 1) occupies the voice through its steps: rom read with the gain step,
// then two multiplies (sine magnitude by gain, then by level) on the shared
// datapath, then rounding, mixing and saturation into the output register.
// the sequencer handles one item at a time, so a tick holds the voice until
// the output register is free for its result. attack_step sits at address 0 and
// release_step at address 4 of the apb-style port, both 17 bits q1.16.
module midi_sine_voice_ar_envelope import msv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // input item channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [7:0]              in_status_byte,
  input  logic [6:0]              in_note_number,
  input  logic [6:0]              in_velocity,
  input  logic signed [SMP_W-1:0] in_sample_in,
  input  logic [GAIN_W-1:0]       in_level,
  // result item channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] out_sample_out,
  output logic                    out_voice_active,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_AW-1:0]       paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  msv_cmd_t          cmd;
  logic              cfg_we;
  logic [GAIN_W-1:0] attack_step, release_step;

  // write lands on the access phase, no wait states
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_RELEASE) ? {15'd0, release_step}
                                            : {15'd0, attack_step};

  msv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  msv_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status_byte  (in_status_byte),
    .note_number  (in_note_number),
    .velocity     (in_velocity),
    .sample_in    (in_sample_in),
    .level        (in_level),
    .cfg_we       (cfg_we),
    .cfg_sel      (paddr[2]),
    .cfg_wdata    (pwdata[GAIN_W-1:0]),
    .attack_step  (attack_step),
    .release_step (release_step),
    .sample_out   (out_sample_out),
    .voice_active (out_voice_active)
  );

endmodule

// ===== design/msv_ctrl.sv =====
// sequencer for midi and tick items
module msv_ctrl import msv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output msv_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_P1, S_P2, S_FIN} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc_in, out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc_in    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          cmd.tick_go = in_cmd;
          cmd.midi_go = !in_cmd;
          if (in_cmd) state_nxt = S_P1;
        end
      end
      S_P1: begin
        cmd.ld_p1 = 1'b1;
        state_nxt = S_P2;
      end
      S_P2: begin
        cmd.ld_p2 = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/msv_dp.sv =====
// voice state, gain ramp, sine rom, multiplies and mix saturation
module msv_dp import msv_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  msv_cmd_t                 cmd,
  input  logic [7:0]               status_byte,
  input  logic [6:0]               note_number,
  input  logic [6:0]               velocity,
  input  logic signed [SMP_W-1:0]  sample_in,
  input  logic [GAIN_W-1:0]        level,
  input  logic                     cfg_we,
  input  logic                     cfg_sel,
  input  logic [GAIN_W-1:0]        cfg_wdata,
  output logic [GAIN_W-1:0]        attack_step,
  output logic [GAIN_W-1:0]        release_step,
  output logic signed [SMP_W-1:0]  sample_out,
  output logic                     voice_active
);

  localparam sine_rom_t SINE_ROM = msv_build_sine();
  localparam inc_rom_t  INC_ROM  = msv_build_inc();
  localparam vel_rom_t  VEL_ROM  = msv_build_vel();

  logic [GAIN_W-1:0]       attack_r, release_r;
  logic [PHASE_W-1:0]      phase_r;
  logic [GAIN_W-1:0]       gain_r, target_r;
  logic [6:0]              held_r;
  logic                    snd_r;

  logic signed [SMP_W-1:0] rom_q_r;
  logic signed [SMP_W-1:0] smp_r;
  logic [GAIN_W-1:0]       level_r;
  logic                    tick_snd_r, act_r;
  logic [39:0]             p1_r;
  logic [56:0]             p2_r;
  logic signed [SMP_W-1:0] out_smp_r;
  logic                    out_act_r;

  logic [GAIN_W:0]         g_up, g_diff;
  logic [GAIN_W-1:0]       gain_nxt;
  logic [SMP_W-1:0]        rom_neg;
  logic [22:0]             mag;
  logic [56:0]             rnd;
  logic [24:0]             voice;
  logic signed [25:0]      acc;
  logic signed [SMP_W-1:0] sat;

  assign attack_step  = attack_r;
  assign release_step = release_r;
  assign sample_out   = out_smp_r;
  assign voice_active = out_act_r;

  // gain ramp toward the target
  always_comb begin
    g_up     = {1'b0, gain_r} + {1'b0, attack_r};
    g_diff   = {1'b0, gain_r} - {1'b0, target_r};
    gain_nxt = gain_r;
    if (gain_r < target_r) begin
      gain_nxt = (g_up > {1'b0, target_r}) ? target_r : g_up[GAIN_W-1:0];
    end else if (gain_r > target_r) begin
      gain_nxt = (g_diff <= {1'b0, release_r}) ? target_r : gain_r - release_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= ATTACK_RST;
      release_r <= RELEASE_RST;
      phase_r   <= '0;
      gain_r    <= '0;
      target_r  <= '0;
      held_r    <= '0;
      snd_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == REG_ATTACK) attack_r <= cfg_wdata;
        else                       release_r <= cfg_wdata;
      end
      if (cmd.midi_go) begin
        if (status_byte[7:4] == ST_NOTE_ON && velocity != 7'd0) begin
          held_r   <= note_number;
          target_r <= VEL_ROM[velocity];
          snd_r    <= 1'b1;
        end else if (status_byte[7:4] == ST_NOTE_ON || status_byte[7:4] == ST_NOTE_OFF) begin
          if (note_number == held_r) target_r <= '0;
        end
      end
      if (cmd.tick_go && snd_r) begin
        gain_r  <= gain_nxt;
        phase_r <= phase_r + INC_ROM[held_r];
        if (target_r == '0 && gain_nxt == '0) snd_r <= 1'b0;
      end
    end
  end

  // sine rom read and tick operands
  always_ff @(posedge clk) begin
    if (cmd.tick_go) begin
      rom_q_r    <= SINE_ROM[phase_r[PHASE_W-1 -: SINE_AW]];
      smp_r      <= sample_in;
      level_r    <= (level > GAIN_UNITY) ? GAIN_UNITY : level;
      tick_snd_r <= snd_r;
      act_r      <= snd_r && !(target_r == '0 && gain_nxt == '0);
    end
  end

  assign rom_neg = -rom_q_r;
  assign mag     = rom_q_r[SMP_W-1] ? rom_neg[22:0] : rom_q_r[22:0];

  always_ff @(posedge clk) begin
    if (cmd.ld_p1) p1_r <= {17'd0, mag} * {23'd0, gain_r};
    if (cmd.ld_p2) p2_r <= {17'd0, p1_r} * {40'd0, level_r};
  end

  // round, apply sign, mix and saturate
  always_comb begin
    rnd   = p2_r + 57'h0_8000_0000;
    voice = rnd[56:32];
    acc   = {{2{smp_r[SMP_W-1]}}, smp_r};
    if (tick_snd_r) begin
      if (rom_q_r[SMP_W-1]) acc = acc - $signed({1'b0, voice});
      else                  acc = acc + $signed({1'b0, voice});
    end
    if (acc > 26'sd8388607)       sat = 24'sh7FFFFF;
    else if (acc < -26'sd8388608) sat = 24'sh800000;
    else                          sat = acc[SMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_out) begin
      out_smp_r <= sat;
      out_act_r <= act_r;
    end
  end

endmodule

// ===== design/msv_checker.sv =====
// port-level checks for the sine voice, bound to the top level
module msv_checker import msv_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_cmd,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [SMP_W-1:0] out_sample_out
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample_out))
    else $error("result payload changed while stalled");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd |=> !in_ready)
    else $error("tick item did not occupy the voice");

  a_midi_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_cmd && !out_valid |=> !out_valid)
    else $error("midi item produced a result");

endmodule

bind midi_sine_voice_ar_envelope msv_checker u_msv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_cmd         (in_cmd),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);
